// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on i_clk, masked during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle check");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/eet_pkg.sv =====
// ---------------------------------------------------------------------------
// eet_pkg
// beat types, register map and fault type decode for the event throttle
// ---------------------------------------------------------------------------
`default_nettype none

package eet_pkg;

    // number of fault types with a defined decode
    localparam logic [4:0] KNOWN_TYPES = 5'd18;

    // register map, indexed by paddr[2]
    localparam logic [0:0] REG_QUIET_WINDOW  = 1'b0;
    localparam logic [0:0] REG_RESET_HOLDOFF = 1'b1;

    // register reset values
    localparam logic [31:0] QUIET_WINDOW_RESET  = 32'd60000;
    localparam logic [15:0] RESET_HOLDOFF_RESET = 16'd200;

    // input beat
    typedef struct packed {
        logic [4:0]  event_type;
        logic [31:0] now_ms;
        logic [31:0] since_reset_ms;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [3:0]  alert_code;
        logic [31:0] event_count;
    } t_out_beat;

    // per type decode
    typedef struct packed {
        logic [3:0] err_code;
        logic [3:0] warn_code;
        logic       counted;
        logic       gated;
        logic       esc;
    } t_type_info;

    // fault type to codes and flags; unknown types decode to all zero
    function automatic t_type_info type_info(input logic [4:0] ev_type);
        t_type_info ti;
        ti = '0;
        case (ev_type)
            5'd0:    ti = '{4'd0,  4'd1,  1'b1, 1'b1, 1'b1};
            5'd1:    ti = '{4'd2,  4'd3,  1'b1, 1'b1, 1'b1};
            5'd2:    ti = '{4'd1,  4'd1,  1'b1, 1'b1, 1'b0};
            5'd3:    ti = '{4'd3,  4'd3,  1'b1, 1'b1, 1'b0};
            5'd4:    ti = '{4'd4,  4'd5,  1'b1, 1'b1, 1'b1};
            5'd5:    ti = '{4'd6,  4'd7,  1'b1, 1'b1, 1'b1};
            5'd6:    ti = '{4'd5,  4'd5,  1'b1, 1'b1, 1'b0};
            5'd7:    ti = '{4'd7,  4'd7,  1'b1, 1'b1, 1'b0};
            5'd8:    ti = '{4'd8,  4'd8,  1'b1, 1'b1, 1'b0};
            5'd9:    ti = '{4'd9,  4'd9,  1'b1, 1'b0, 1'b0};
            5'd10:   ti = '{4'd10, 4'd11, 1'b1, 1'b0, 1'b1};
            5'd11:   ti = '{4'd11, 4'd11, 1'b1, 1'b0, 1'b0};
            5'd12:   ti = '{4'd10, 4'd10, 1'b0, 1'b0, 1'b0};
            5'd13:   ti = '{4'd12, 4'd12, 1'b0, 1'b0, 1'b0};
            5'd14:   ti = '{4'd9,  4'd9,  1'b1, 1'b0, 1'b0};
            5'd15:   ti = '{4'd13, 4'd13, 1'b1, 1'b0, 1'b0};
            5'd16:   ti = '{4'd14, 4'd14, 1'b1, 1'b1, 1'b0};
            5'd17:   ti = '{4'd15, 4'd15, 1'b1, 1'b1, 1'b0};
            default: ti = '0;
        endcase
        return ti;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/eet_ram.sv =====
// ---------------------------------------------------------------------------
// eet_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module eet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/error_event_throttle_core.sv =====
// ---------------------------------------------------------------------------
// error_event_throttle_core
// per type fault event counter and rate limiter with notify code decode
// ---------------------------------------------------------------------------
// Usage: fault events enter on the input channel (valid/stall), one beat per
// event carrying type, current ms time and ms since device reset. Each known
// event gives zero or one beat on the output channel with a notify code and
// the type's occurrence count. Types at or beyond the known set give nothing.
// Beats go from the state stage through the output register. One event is
// taken per cycle when the output is not stalled: the per type state ram is
// read at accept and written back as the event leaves the stage, with the
// just-written word forwarded when the next event hits the same type.
// Throttle registers sit on the APB port: quiet window at 0x0, reset
// hold-off at 0x4. Write them only while no event is in flight.
// Reset clears counts and report times at once through per entry valid
// bits, so events are taken on the first cycle after reset.
// A stalled output holds its beat; one more event may enter the state stage
// and wait there with its update pending, then the input stalls until the
// output drains.
// ---------------------------------------------------------------------------
`default_nettype none

module error_event_throttle_core #(
    parameter int NUM_TYPES      = 18,
    parameter int ESCALATE_EVERY = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire eet_pkg::t_in_beat i_in_data,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output eet_pkg::t_out_beat     o_out_data,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int AW     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int RW     = (ESCALATE_EVERY > 1) ? $clog2(ESCALATE_EVERY) : 1;
    localparam int WORD_W = 32 + RW + 32;
    localparam logic [5:0]    NT      = 6'(NUM_TYPES);
    localparam logic [RW-1:0] RES_TOP = RW'(ESCALATE_EVERY - 1);

    // configuration registers
    logic [31:0] r_quiet_window;
    logic [15:0] r_reset_holdoff;
    logic        w_cfg_wr;

    // state stage
    logic             r_s_valid;
    logic [4:0]       r_s_type;
    logic [31:0]      r_s_now;
    logic [31:0]      r_s_since;
    logic             r_s_fwd_hit;
    logic             r_s_ent_vld;
    logic [WORD_W-1:0] r_fwd_word;
    logic [NUM_TYPES-1:0] r_ent_vld;

    // output register
    logic               r_out_valid;
    eet_pkg::t_out_beat r_out_data;

    // ram ports
    logic              w_in_acc;
    logic              w_in_known;
    logic [AW-1:0]     w_in_addr;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;
    logic [WORD_W-1:0] w_rd_data;

    // stage compute
    logic                w_s_adv;
    logic                w_s_known;
    eet_pkg::t_type_info w_s_info;
    logic [WORD_W-1:0]   w_s_word;
    logic [31:0]         w_prev_cnt;
    logic [RW-1:0]       w_prev_res;
    logic [31:0]         w_last_time;
    logic [31:0]         w_new_cnt;
    logic [RW-1:0]       w_new_res;
    logic [31:0]         w_delta;
    logic                w_quiet;
    logic                w_held;
    logic                w_report;
    logic [31:0]         w_new_time;
    eet_pkg::t_out_beat  w_res_beat;

    // apb write and read
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_window  <= eet_pkg::QUIET_WINDOW_RESET;
            r_reset_holdoff <= eet_pkg::RESET_HOLDOFF_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                eet_pkg::REG_QUIET_WINDOW:  r_quiet_window  <= pwdata;
                eet_pkg::REG_RESET_HOLDOFF: r_reset_holdoff <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            eet_pkg::REG_QUIET_WINDOW:  prdata = r_quiet_window;
            eet_pkg::REG_RESET_HOLDOFF: prdata = {16'd0, r_reset_holdoff};
            default:                    prdata = '0;
        endcase
    end

    // input accept and ram read
    assign w_s_adv    = r_s_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s_valid && !w_s_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_in_known = (i_in_data.event_type < eet_pkg::KNOWN_TYPES) &&
                        ({1'b0, i_in_data.event_type} < NT);
    assign w_in_addr  = i_in_data.event_type[AW-1:0];

    eet_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_TYPES)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_acc && w_in_known),
        .i_rd_addr (w_in_addr),
        .o_rd_data (w_rd_data)
    );

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s_valid <= 1'b1;
        end else if (w_s_adv) begin
            r_s_valid <= 1'b0;
        end
    end

    // stage payload, forward flag set when the write lands on the read entry
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s_type    <= i_in_data.event_type;
            r_s_now     <= i_in_data.now_ms;
            r_s_since   <= i_in_data.since_reset_ms;
            r_s_fwd_hit <= w_wr_en && (w_wr_addr == w_in_addr);
            r_s_ent_vld <= w_in_known && r_ent_vld[w_in_addr];
        end
        if (w_wr_en) begin
            r_fwd_word <= w_wr_data;
        end
    end

    // entry valid bits stand in for the cleared reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (w_wr_en) begin
            r_ent_vld[w_wr_addr] <= 1'b1;
        end
    end

    // read-modify-write of the type entry
    always_comb begin
        w_s_info  = eet_pkg::type_info(r_s_type);
        w_s_known = (r_s_type < eet_pkg::KNOWN_TYPES) && ({1'b0, r_s_type} < NT);

        if (r_s_fwd_hit) begin
            w_s_word = r_fwd_word;
        end else if (r_s_ent_vld) begin
            w_s_word = w_rd_data;
        end else begin
            w_s_word = '0;
        end
        w_prev_cnt  = w_s_word[WORD_W-1 -: 32];
        w_prev_res  = w_s_word[32 +: RW];
        w_last_time = w_s_word[31:0];

        // saturating count, residue of the count modulo the escalation period
        if (w_prev_cnt == 32'hFFFF_FFFF) begin
            w_new_cnt = w_prev_cnt;
            w_new_res = w_prev_res;
        end else begin
            w_new_cnt = w_prev_cnt + 32'd1;
            w_new_res = (w_prev_res == RES_TOP) ? '0 : w_prev_res + RW'(1);
        end

        // quiet window and reset hold-off
        w_delta  = r_s_now - w_last_time;
        w_quiet  = (w_prev_cnt != 32'd0) && (w_delta < r_quiet_window);
        w_held   = w_s_info.gated && (r_s_since < {16'd0, r_reset_holdoff});
        w_report = w_s_known && (!w_s_info.counted || (!w_quiet && !w_held));
        w_new_time = w_report ? r_s_now : w_last_time;

        // result beat
        if (!w_s_info.counted) begin
            w_res_beat.alert_code  = w_s_info.err_code;
            w_res_beat.event_count = '0;
        end else begin
            w_res_beat.alert_code  = (w_s_info.esc && (w_new_res != '0)) ?
                                     w_s_info.warn_code : w_s_info.err_code;
            w_res_beat.event_count = w_new_cnt;
        end

        // write back
        w_wr_en   = w_s_adv && w_s_known && w_s_info.counted;
        w_wr_addr = r_s_type[AW-1:0];
        w_wr_data = {w_new_cnt, w_new_res, w_new_time};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s_adv && w_report) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_adv && w_report) begin
            r_out_data <= w_res_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // assertions
    `include "assert_macros.svh"

    `ASSERT_NEXT(a_fwd_flag, w_in_acc && w_wr_en && (w_wr_addr == w_in_addr), r_s_fwd_hit)
    `ASSERT_SAME(a_wr_from_stage, w_wr_en, r_s_valid && w_s_adv && w_s_info.counted)
    `ASSERT_NEXT(a_report_loads, w_s_adv && w_report, r_out_valid)
    `ASSERT_NEXT(a_wr_sets_vld, w_wr_en, r_ent_vld[$past(w_wr_addr)])

endmodule

`default_nettype wire
